FILE: hdl/assert_macros.svh
// Assertion macros used by the verification checker of the project.
// Depends on nothing; included by the checker file by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, disabled while the active-low reset is asserted.
`define ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("%m: check failed");

// Concurrent assertion that also holds during reset.
`define ASSERT_CLK_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("%m: check failed");

`endif

FILE: hdl/pmic_rc_pkg.sv
// Shared types, codes, register defaults and voltage tables of the regulator control block.
// Depends on nothing; used by every module of the block.
package pmic_rc_pkg;

    localparam int REG_COUNT = 16;
    localparam int ADDR_W = $clog2(REG_COUNT);

    localparam logic [7:0] RESET_BYTES [REG_COUNT] = '{
        8'hFA, 8'hB1, 8'hFF, 8'hF9,
        8'h99, 8'h99, 8'h99, 8'h02,
        8'h88, 8'h02, 8'h0C, 8'h0A,
        8'h0E, 8'h33, 8'h0E, 8'h16
    };

    localparam logic [21:0] LIMIT_LO_UV = 22'd800000;
    localparam logic [21:0] LIMIT_HI_UV = 22'd3601000;
    localparam logic [21:0] MV_UV = 22'd1000;

    typedef enum logic [2:0] {
        REQ_QUERY   = 3'd0,
        REQ_ENABLE  = 3'd1,
        REQ_DISABLE = 3'd2,
        REQ_GET     = 3'd3,
        REQ_SET     = 3'd4
    } req_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_RANGE   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        TAB_LOW  = 2'd0,
        TAB_MID  = 2'd1,
        TAB_HIGH = 2'd2,
        TAB_CORE = 2'd3
    } tab_t;

    typedef enum logic [1:0] {
        FLD_LO   = 2'd0,
        FLD_HI   = 2'd1,
        FLD_BYTE = 2'd2
    } fld_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } shadow_wr_t;

    typedef struct packed {
        status_t     status;
        logic        enabled;
        logic [21:0] voltage_microvolts;
        logic        write_valid;
        logic [3:0]  write_addr;
        logic [7:0]  write_data;
    } result_t;

    function automatic logic [4:0] tab_len(tab_t sel);
        logic [4:0] n;
        case (sel)
            TAB_LOW:  n = 5'd11;
            TAB_MID:  n = 5'd21;
            TAB_HIGH: n = 5'd7;
            TAB_CORE: n = 5'd16;
            default:  n = 5'd0;
        endcase
        return n;
    endfunction

    function automatic logic [21:0] tab_uv(tab_t sel, logic [4:0] idx);
        logic [21:0] uv;
        uv = 22'd0;
        if (idx < tab_len(sel)) begin
            case (sel)
                TAB_LOW:  uv = 22'd800000 + 22'(idx) * 22'd50000;
                TAB_MID:  uv = 22'd1600000 + 22'(idx) * 22'd100000;
                TAB_HIGH: uv = 22'd3000000 + 22'(idx) * 22'd100000;
                TAB_CORE: uv = 22'd750000 + 22'(idx) * 22'd50000;
                default:  uv = 22'd0;
            endcase
        end
        return uv;
    endfunction

endpackage

FILE: hdl/pmic_regulator_control_regs_top.sv
// Top level of the regulator control block: request register, evaluation, result register.
// Depends on pmic_rc_pkg, pmic_rc_shadow and pmic_rc_exec.
//
// Requests enter on the s_ stream channel: s_tuser carries the request type, s_tdata the
// regulator number and the minimum and maximum voltages in microvolts. Each request gives
// exactly one result on the m_ stream channel: m_tuser carries the status, m_tdata the
// enable bit, the decoded voltage and the register write that the request made, if any.
// A request is taken into an input register, evaluated combinationally against the register
// shadow and then written into the result register. One request is accepted every cycle while
// the receiver does not stall; the shadow read-modify-write completes in the same cycle in
// which a request moves to the result register, so the following request already sees the
// updated byte.
// Synchronous active-low reset empties both registers and loads the shadow with the chip
// defaults. When the receiver stalls, the result register holds its request and the input
// register holds one more; s_tready falls once both are full.
module pmic_regulator_control_regs_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // regulator_id[3:0], min_microvolts[25:4], max_microvolts[47:26]
    input  logic [2:0]  s_tuser,  // req_type[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // enabled[0], voltage_microvolts[22:1], write_valid[23],
                                  // write_addr[27:24], write_data[35:28], zero[39:36]
    output logic [1:0]  m_tuser   // status[1:0]
);

    logic        in_valid_reg, in_valid_next;
    logic [2:0]  in_type_reg, in_type_next;
    logic [3:0]  in_id_reg, in_id_next;
    logic [21:0] in_min_reg, in_min_next;
    logic [21:0] in_max_reg, in_max_next;
    logic        out_valid_reg, out_valid_next;
    pmic_rc_pkg::result_t out_res_reg, out_res_next;

    logic                          move;
    logic                          take;
    logic [pmic_rc_pkg::ADDR_W-1:0] rd_addr;
    logic [7:0]                    rd_data;
    pmic_rc_pkg::shadow_wr_t       exec_wr;
    pmic_rc_pkg::shadow_wr_t       shadow_wr;
    pmic_rc_pkg::result_t          exec_res;

    assign move     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || move;
    assign take     = s_tvalid && s_tready;

    pmic_rc_exec u_exec (
        .req_type       (in_type_reg),
        .regulator_id   (in_id_reg),
        .min_microvolts (in_min_reg),
        .max_microvolts (in_max_reg),
        .rd_addr        (rd_addr),
        .rd_data        (rd_data),
        .wr             (exec_wr),
        .res            (exec_res)
    );

    always_comb begin
        shadow_wr    = exec_wr;
        shadow_wr.en = exec_wr.en && move;
    end

    pmic_rc_shadow u_shadow (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (shadow_wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        in_type_next  = in_type_reg;
        in_id_next    = in_id_reg;
        in_min_next   = in_min_reg;
        in_max_next   = in_max_reg;
        if (take) begin
            in_valid_next = 1'b1;
            in_type_next  = s_tuser;
            in_id_next    = s_tdata[3:0];
            in_min_next   = s_tdata[25:4];
            in_max_next   = s_tdata[47:26];
        end else if (move) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (move) begin
            out_valid_next = 1'b1;
            out_res_next   = exec_res;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_type_reg <= in_type_next;
        in_id_reg   <= in_id_next;
        in_min_reg  <= in_min_next;
        in_max_reg  <= in_max_next;
        out_res_reg <= out_res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.status;
    assign m_tdata  = {4'd0, out_res_reg.write_data, out_res_reg.write_addr,
                       out_res_reg.write_valid, out_res_reg.voltage_microvolts,
                       out_res_reg.enabled};

endmodule

FILE: hdl/pmic_rc_shadow.sv
// Shadow copy of the sixteen control registers, loaded with the chip defaults at reset.
// Depends on pmic_rc_pkg for the defaults and the write port type.
module pmic_rc_shadow (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  pmic_rc_pkg::shadow_wr_t       wr,
    input  logic [pmic_rc_pkg::ADDR_W-1:0] rd_addr,
    output logic [7:0]                    rd_data
);

    logic [7:0] shadow_reg [pmic_rc_pkg::REG_COUNT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < pmic_rc_pkg::REG_COUNT; i++) begin
                shadow_reg[i] <= pmic_rc_pkg::RESET_BYTES[i];
            end
        end else if (wr.en) begin
            shadow_reg[wr.addr] <= wr.data;
        end
    end

    assign rd_data = shadow_reg[rd_addr];

endmodule

FILE: hdl/pmic_rc_exec.sv
// Request evaluation: decodes the regulator, reads or updates its register byte, searches tables.
// Depends on pmic_rc_pkg for codes, tables and the result and write types.
module pmic_rc_exec (
    input  logic [2:0]                     req_type,
    input  logic [3:0]                     regulator_id,
    input  logic [21:0]                    min_microvolts,
    input  logic [21:0]                    max_microvolts,
    output logic [pmic_rc_pkg::ADDR_W-1:0] rd_addr,
    input  logic [7:0]                     rd_data,
    output pmic_rc_pkg::shadow_wr_t        wr,
    output pmic_rc_pkg::result_t           res
);

    logic                          req_ok;
    logic [pmic_rc_pkg::ADDR_W-1:0] en_addr;
    logic [2:0]                    en_bit;
    logic [7:0]                    en_byte;
    logic [pmic_rc_pkg::ADDR_W-1:0] fld_addr;
    pmic_rc_pkg::fld_t             fld;
    pmic_rc_pkg::tab_t             tab;
    logic [4:0]                    tab_n;
    logic [7:0]                    code;
    logic [4:0]                    pick;
    logic [7:0]                    set_byte;
    logic                          set_ok;

    always_comb begin
        if (regulator_id <= 4'd5) begin
            en_addr = '0;
            en_bit  = 3'(4'd6 - regulator_id);
        end else if (regulator_id <= 4'd9) begin
            en_addr = pmic_rc_pkg::ADDR_W'(1);
            en_bit  = 3'(4'd13 - regulator_id);
        end else begin
            en_addr = '0;
            en_bit  = 3'(5'd17 - 5'(regulator_id));
        end

        fld = pmic_rc_pkg::FLD_BYTE;
        case (regulator_id)
            4'd2: begin
                fld_addr = pmic_rc_pkg::ADDR_W'(8);
                fld      = pmic_rc_pkg::FLD_LO;
            end
            4'd3: begin
                fld_addr = pmic_rc_pkg::ADDR_W'(8);
                fld      = pmic_rc_pkg::FLD_HI;
            end
            4'd8: begin
                fld_addr = pmic_rc_pkg::ADDR_W'(13);
                fld      = pmic_rc_pkg::FLD_HI;
            end
            4'd10: begin
                fld_addr = pmic_rc_pkg::ADDR_W'(4);
                fld      = pmic_rc_pkg::FLD_LO;
            end
            4'd11: begin
                fld_addr = pmic_rc_pkg::ADDR_W'(6);
                fld      = pmic_rc_pkg::FLD_LO;
            end
            4'd12:   fld_addr = pmic_rc_pkg::ADDR_W'(7);
            default: fld_addr = pmic_rc_pkg::ADDR_W'(regulator_id + 4'd5);
        endcase

        if (regulator_id <= 4'd3) begin
            tab = pmic_rc_pkg::TAB_LOW;
        end else if (regulator_id == 4'd8) begin
            tab = pmic_rc_pkg::TAB_HIGH;
        end else if (regulator_id == 4'd10 || regulator_id == 4'd11) begin
            tab = pmic_rc_pkg::TAB_CORE;
        end else begin
            tab = pmic_rc_pkg::TAB_MID;
        end
        tab_n = pmic_rc_pkg::tab_len(tab);

        rd_addr = (req_type <= pmic_rc_pkg::REQ_DISABLE) ? en_addr : fld_addr;

        case (fld)
            pmic_rc_pkg::FLD_LO: code = {4'd0, rd_data[3:0]};
            pmic_rc_pkg::FLD_HI: code = {4'd0, rd_data[7:4]};
            default:             code = rd_data;
        endcase

        // The tables ascend, so the first entry above the minimum less one millivolt wins.
        pick = tab_n;
        for (int k = 20; k >= 0; k--) begin
            if (5'(k) < tab_n &&
                min_microvolts < pmic_rc_pkg::tab_uv(tab, 5'(k)) + pmic_rc_pkg::MV_UV) begin
                pick = 5'(k);
            end
        end
        set_ok = min_microvolts >= pmic_rc_pkg::LIMIT_LO_UV &&
                 max_microvolts < pmic_rc_pkg::LIMIT_HI_UV &&
                 pick < tab_n &&
                 max_microvolts >= pmic_rc_pkg::tab_uv(tab, pick);

        case (fld)
            pmic_rc_pkg::FLD_LO: set_byte = {rd_data[7:4], pick[3:0]};
            pmic_rc_pkg::FLD_HI: set_byte = {pick[3:0], rd_data[3:0]};
            default:             set_byte = {3'd0, pick};
        endcase

        en_byte = rd_data;
        en_byte[en_bit] = (req_type == pmic_rc_pkg::REQ_ENABLE);

        req_ok = regulator_id >= 4'd1 && regulator_id <= 4'd12 &&
                 req_type <= pmic_rc_pkg::REQ_SET;

        res     = '0;
        wr      = '0;
        wr.addr = rd_addr;
        if (!req_ok) begin
            res.status = pmic_rc_pkg::ST_INVALID;
        end else begin
            case (req_type)
                pmic_rc_pkg::REQ_QUERY: res.enabled = rd_data[en_bit];
                pmic_rc_pkg::REQ_ENABLE, pmic_rc_pkg::REQ_DISABLE: begin
                    wr.en   = 1'b1;
                    wr.data = en_byte;
                end
                pmic_rc_pkg::REQ_GET: begin
                    if (code < 8'(tab_n)) begin
                        res.voltage_microvolts = pmic_rc_pkg::tab_uv(tab, code[4:0]);
                    end else begin
                        res.status = pmic_rc_pkg::ST_RANGE;
                    end
                end
                default: begin
                    if (set_ok) begin
                        wr.en   = 1'b1;
                        wr.data = set_byte;
                    end else begin
                        res.status = pmic_rc_pkg::ST_INVALID;
                    end
                end
            endcase
        end
        res.write_valid = wr.en;
        res.write_addr  = wr.en ? 4'(wr.addr) : 4'd0;
        res.write_data  = wr.en ? wr.data : 8'd0;
    end

endmodule

FILE: hdl/pmic_rc_checker.sv
// Port-level checks of the regulator control block, bound to its top level.
// Depends on assert_macros.svh and pmic_rc_pkg for the status codes.
`include "assert_macros.svh"

module pmic_rc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [1:0]  m_tuser
);

    logic        wr_valid;
    logic [11:0] wr_fields;
    logic [21:0] volt;
    logic        st_ok;

    assign wr_valid  = m_tdata[23];
    assign wr_fields = m_tdata[35:24];
    assign volt      = m_tdata[22:1];
    assign st_ok     = (m_tuser == pmic_rc_pkg::ST_OK);

    `ASSERT_CLK(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    `ASSERT_CLK_NR(a_reset_empty, aclk, !aresetn |=> !m_tvalid)
    `ASSERT_CLK(a_no_write_zero, aclk, aresetn, m_tvalid && !wr_valid |-> wr_fields == 12'd0)
    `ASSERT_CLK(a_fail_no_write, aclk, aresetn, m_tvalid && !st_ok |-> !wr_valid)
    `ASSERT_CLK(a_volt_only_ok, aclk, aresetn, m_tvalid && volt != 22'd0 |-> st_ok && !wr_valid)

endmodule

bind pmic_regulator_control_regs_top pmic_rc_checker u_pmic_rc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
